[src/dc_motor_pwm_ramp_controller_defines.svh]
// Assertion macros shared by the motor ramp controller RTL.
`ifndef DC_MOTOR_PWM_RAMP_CONTROLLER_DEFINES_SVH
`define DC_MOTOR_PWM_RAMP_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define DMPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define DMPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define DMPR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DMPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/dmpr_pkg.sv]
// Types and constants for the motor PWM ramp controller.
package dmpr_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_GO    = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_ESTOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_UP       = 2'd1,
        MODE_DOWN     = 2'd2,
        MODE_AT_SPEED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_LOWER = 2'd1,
        STAT_UPPER = 2'd2,
        STAT_RSVD  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_RAMP_SETTING = 2'd0,
        CFG_LOWER_EN     = 2'd1,
        CFG_UPPER_EN     = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    localparam int          CFG_DATA_W      = 4;
    localparam int          CFG_IDX_W       = 2;
    localparam int          DUTY_W          = 8;
    localparam int          SPEED_W         = 7;
    localparam int          COUNT_W         = 15;
    localparam logic [3:0]  RAMP_SETTING_MAX = 4'd9;
    localparam logic [3:0]  RAMP_SETTING_RST = 4'd4;
    localparam logic [6:0]  SPEED_FULL      = 7'd100;
    localparam logic [7:0]  DUTY_TOP        = 8'd255;

    typedef struct packed {
        mode_t                mode;
        logic                 dir;
        logic [DUTY_W-1:0]    duty;
        logic [DUTY_W-1:0]    target;
        logic                 step_down;
        logic [COUNT_W-1:0]   countdown;
        logic                 rev_pend;
        logic                 pend_dir;
        logic [DUTY_W-1:0]    pend_target;
    } mtr_state_t;

endpackage

[src/dc_motor_pwm_ramp_controller.sv]
// Top level of the H-bridge PWM speed ramp controller.
// The result of an input transfer is loaded into the output register at the clock edge that accepts it.
// Throughput: one item per cycle while in_ready is high; the state update for each item is a single
//   registered pass (speed table lookup, ramp compare, countdown load).
// in_ready drops only while a result waits in the output register and out_ready is low.
// Reset (rst_n, async low): motor stopped, direction 0, duty 0, ramp_setting 4,
//   both limit checks off, no result pending.
`include "dc_motor_pwm_ramp_controller_defines.svh"

module dc_motor_pwm_ramp_controller #(
    parameter int MAX_DUTY        = 250,
    parameter int RAMP_UNIT_TICKS = 2000
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [dmpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmpr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic                            direction_req,
    input  logic [dmpr_pkg::SPEED_W-1:0]    speed_percent,
    input  logic                            lower_switch_closed,
    input  logic                            upper_switch_closed,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [1:0]                      motor_mode,
    output logic                            direction_now,
    output logic [dmpr_pkg::DUTY_W-1:0]     duty_first,
    output logic [dmpr_pkg::DUTY_W-1:0]     duty_second
);

    import dmpr_pkg::*;

    // Ramp period is a 16-bit unit times (setting + 1), at most 21 bits wide.
    localparam int          PROD_W    = 21;
    localparam logic [PROD_W-1:0] UNIT_TICKS = PROD_W'(RAMP_UNIT_TICKS);
    localparam logic [PROD_W-1:0] COUNT_SAT  = PROD_W'((1 << COUNT_W) - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0] ramp_setting_reg;
    logic       lower_en_reg;
    logic       upper_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_setting_reg <= RAMP_SETTING_RST;
            lower_en_reg     <= 1'b0;
            upper_en_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RAMP_SETTING:
                begin
                    // out-of-range settings are dropped
                    if (cfg_data <= RAMP_SETTING_MAX)
                        ramp_setting_reg <= cfg_data;
                end
                CFG_LOWER_EN: lower_en_reg <= cfg_data[0];
                CFG_UPPER_EN: upper_en_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Speed percent to target duty: constant table, filled at elaboration
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0] target_lut [0:100];

    for (genvar gi = 0; gi <= 100; gi++)
    begin : g_lut
        assign target_lut[gi] = DUTY_W'((gi * MAX_DUTY) / 100);
    end

    logic [SPEED_W-1:0] speed_sat;
    logic [DUTY_W-1:0]  go_target;

    assign speed_sat = (speed_percent > SPEED_FULL) ? SPEED_FULL : speed_percent;
    assign go_target = target_lut[speed_sat];

    // ------------------------------------------------------------------
    // Ramp period reload value, saturated to the countdown range
    // ------------------------------------------------------------------
    logic [4:0]         setting_p1;
    logic [PROD_W-1:0]  period_full;
    logic [COUNT_W-1:0] reload;

    assign setting_p1  = {1'b0, ramp_setting_reg} + 5'd1;
    assign period_full = UNIT_TICKS * PROD_W'(setting_p1);
    assign reload      = (period_full > COUNT_SAT) ? COUNT_W'(COUNT_SAT - PROD_W'(1))
                                                   : COUNT_W'(period_full - PROD_W'(1));

    // ------------------------------------------------------------------
    // Motor state and next-state logic
    // ------------------------------------------------------------------
    mtr_state_t st_reg;
    mtr_state_t st_next;
    status_t    stat_next;
    logic       accept;

    // emergency halt: stop, zero duty, drop any waiting reversal
    function automatic mtr_state_t halt_fn(input mtr_state_t s);
        mtr_state_t r;
        r          = s;
        r.mode     = MODE_STOPPED;
        r.duty     = '0;
        r.rev_pend = 1'b0;
        return r;
    endfunction

    // start from standstill; a zero target leaves the motor as it is
    function automatic mtr_state_t start_fn(input mtr_state_t s, input logic d,
                                            input logic [DUTY_W-1:0] t);
        mtr_state_t r;
        r = s;
        if (t != '0)
        begin
            r.dir       = d;
            r.duty      = '0;
            r.target    = t;
            r.step_down = 1'b0;
            r.countdown = '0;
            r.mode      = MODE_UP;
        end
        return r;
    endfunction

    always_comb
    begin
        logic [DUTY_W-1:0] duty_step;
        mtr_state_t        s;

        s         = st_reg;
        stat_next = STAT_OK;
        duty_step = st_reg.duty;

        unique case (cmd_t'(command))
            CMD_TICK:
            begin
                if (s.mode != MODE_STOPPED)
                begin
                    if (lower_en_reg && lower_switch_closed)
                    begin
                        s         = halt_fn(s);
                        stat_next = STAT_LOWER;
                    end
                    else if (upper_en_reg && upper_switch_closed)
                    begin
                        s         = halt_fn(s);
                        stat_next = STAT_UPPER;
                    end
                    else if (s.mode != MODE_AT_SPEED)
                    begin
                        if (s.countdown != '0)
                            s.countdown = s.countdown - COUNT_W'(1);
                        else
                        begin
                            if (s.step_down)
                                duty_step = (s.duty != '0) ? s.duty - DUTY_W'(1) : s.duty;
                            else
                                duty_step = (s.duty != DUTY_TOP) ? s.duty + DUTY_W'(1)
                                                                 : s.duty;
                            s.duty = duty_step;
                            if (duty_step == s.target)
                            begin
                                if (s.target == '0)
                                begin
                                    s.mode = MODE_STOPPED;
                                    s.duty = '0;
                                    if (s.rev_pend)
                                    begin
                                        s.rev_pend = 1'b0;
                                        s = start_fn(s, s.pend_dir, s.pend_target);
                                    end
                                end
                                else
                                    s.mode = MODE_AT_SPEED;
                            end
                            else
                                s.countdown = reload;
                        end
                    end
                end
            end
            CMD_GO:
            begin
                s.rev_pend = 1'b0;
                if (s.mode == MODE_STOPPED)
                    s = start_fn(s, direction_req, go_target);
                else if (direction_req == s.dir)
                begin
                    s.target = go_target;
                    if (go_target > s.duty)
                    begin
                        s.step_down = 1'b0;
                        s.mode      = MODE_UP;
                    end
                    else if (go_target < s.duty)
                    begin
                        s.step_down = 1'b1;
                        s.mode      = MODE_DOWN;
                    end
                    else
                        s.mode = (go_target == '0) ? MODE_STOPPED : MODE_AT_SPEED;
                end
                else if (s.duty == '0)
                begin
                    // reversal at zero duty starts right away
                    s = halt_fn(s);
                    s = start_fn(s, direction_req, go_target);
                end
                else
                begin
                    s.target    = '0;
                    s.step_down = 1'b1;
                    s.countdown = '0;
                    s.mode      = MODE_DOWN;
                    if (go_target != '0)
                    begin
                        s.rev_pend    = 1'b1;
                        s.pend_dir    = direction_req;
                        s.pend_target = go_target;
                    end
                end
            end
            CMD_STOP:
            begin
                s.rev_pend = 1'b0;
                if (s.mode != MODE_STOPPED)
                begin
                    if (s.duty == '0)
                        s = halt_fn(s);
                    else
                    begin
                        s.target    = '0;
                        s.step_down = 1'b1;
                        s.countdown = '0;
                        s.mode      = MODE_DOWN;
                    end
                end
            end
            CMD_ESTOP: s = halt_fn(s);
            default:   s = halt_fn(s);
        endcase

        st_next = s;
    end

    // ------------------------------------------------------------------
    // Handshake: one output register; a new transfer is taken whenever
    // that register is empty or is being drained in the same cycle.
    // ------------------------------------------------------------------
    logic      out_valid_reg;
    status_t   status_reg;
    mode_t     mode_out_reg;
    logic      dir_out_reg;
    logic [DUTY_W-1:0] duty1_reg;
    logic [DUTY_W-1:0] duty2_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                st_reg <= st_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the post-update state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= stat_next;
            mode_out_reg <= st_next.mode;
            dir_out_reg  <= st_next.dir;
            duty1_reg    <= st_next.dir  ? st_next.duty : '0;
            duty2_reg    <= !st_next.dir ? st_next.duty : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign motor_mode    = mode_out_reg;
    assign direction_now = dir_out_reg;
    assign duty_first    = duty1_reg;
    assign duty_second   = duty2_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DMPR_ASSERT_IMPL(a_stopped_zero_duty, clk, rst_n, st_reg.mode == MODE_STOPPED, st_reg.duty == '0)
    `DMPR_ASSERT_IMPL(a_rev_only_ramp_down, clk, rst_n, st_reg.rev_pend, st_reg.mode == MODE_DOWN)
    `DMPR_ASSERT_IMPL(a_at_speed_on_target, clk, rst_n, st_reg.mode == MODE_AT_SPEED, st_reg.duty == st_reg.target && st_reg.target != '0)
    `DMPR_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && in_ready, out_valid)
    `DMPR_ASSERT_IMPL(a_limit_stop_is_stopped, clk, rst_n, out_valid && status != STAT_OK, motor_mode == MODE_STOPPED)

endmodule
